// ----- src/cfc_pkg.sv -----
// Shared types, constants and the CRC-32 byte update for the config frame checker.
// Depends on nothing; every other file imports it.
`default_nettype none

package cfc_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int PHASE_W   = 2;
    localparam int HDR_IDX_W = 4;
    localparam int LEN_W     = 16;
    localparam int CRC_W     = 32;
    localparam int MAGIC_W   = 32;
    localparam int VERSION_W = 8;

    // Header layout
    localparam int HEADER_BYTES = 12;
    localparam logic [HDR_IDX_W-1:0] HDR_MAGIC_FIRST = HDR_IDX_W'(0);
    localparam logic [HDR_IDX_W-1:0] HDR_MAGIC_LAST  = HDR_IDX_W'(3);
    localparam logic [HDR_IDX_W-1:0] HDR_VERSION     = HDR_IDX_W'(4);
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO      = HDR_IDX_W'(6);
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI      = HDR_IDX_W'(7);
    localparam logic [HDR_IDX_W-1:0] HDR_CRC_FIRST   = HDR_IDX_W'(8);
    localparam logic [HDR_IDX_W-1:0] HDR_LAST        = HDR_IDX_W'(HEADER_BYTES - 1);

    // Frame phases
    localparam logic [PHASE_W-1:0] PHASE_HEADER  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_PAYLOAD = 2'd1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_READ_ERROR   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_MAGIC    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_VERSION  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO_LENGTH  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CRC_MISMATCH = 3'd5;

    // CRC-32 (reflected)
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_XOUT = 32'hFFFF_FFFF;

    // Configuration registers
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_WORD     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_VERSION = 1'b1;
    localparam logic [MAGIC_W-1:0]   MAGIC_RESET   = 32'h4F4C_4143;
    localparam logic [VERSION_W-1:0] VERSION_RESET = 8'd1;

    typedef struct packed {
        logic [MAGIC_W-1:0]   magic_word;
        logic [VERSION_W-1:0] format_version;
    } cfc_cfg_t;

    // Fold one byte into the running CRC, one bit per step
    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/cfc_if.sv -----
// Stream channel interfaces for the config frame checker: byte input and result output.
// Depends on cfc_pkg for field widths.
`default_nettype none

interface cfc_in_if
    import cfc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;
    logic              stream_ended;

    modport source (output valid, output stream_byte, output stream_ended, input ready);
    modport sink   (input valid, input stream_byte, input stream_ended, output ready);
endinterface

interface cfc_out_if
    import cfc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   payload_byte;
    logic                payload_valid;
    logic                status_valid;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output payload_byte, output payload_valid,
                    output status_valid, output status, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input status_valid, input status, output ready);
endinterface

`default_nettype wire

// ----- src/cfc_apb_regs.sv -----
// APB-style configuration registers: expected magic word and format version.
// Depends on cfc_pkg for the register map and the cfc_cfg_t struct.
`default_nettype none

module cfc_apb_regs
    import cfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfc_cfg_t                   cfg
);

    logic [MAGIC_W-1:0]   magic_word_reg;
    logic [VERSION_W-1:0] format_version_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg     <= MAGIC_RESET;
            format_version_reg <= VERSION_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MAGIC_WORD:     magic_word_reg     <= pwdata[MAGIC_W-1:0];
                REG_FORMAT_VERSION: format_version_reg <= pwdata[VERSION_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            REG_MAGIC_WORD:     prdata = magic_word_reg;
            REG_FORMAT_VERSION: prdata = {{(CFG_DATA_W-VERSION_W){1'b0}}, format_version_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.magic_word     = magic_word_reg;
    assign cfg.format_version = format_version_reg;

endmodule

`default_nettype wire

// ----- src/config_frame_checker_top.sv -----
// Top level of the config frame checker: header parse, CRC-32 check and result register.
// Depends on cfc_pkg, cfc_if (cfc_in_if, cfc_out_if) and cfc_apb_regs.
//
// Takes one frame byte per beat and sustains one beat per clock: each byte is
// checked by a single level of logic (header field capture, or a byte-wide
// CRC-32 update) and lands in a one-deep result register. stream_in.ready is
// high whenever that register is empty or is being drained in the same cycle,
// so the only source of stalls is back-pressure on result_out. A header beat
// gives no result except the twelfth when it finds bad magic, bad version or
// zero length; each payload beat gives one result carrying the byte, and the
// last one also carries ok or crc mismatch. An end-of-stream beat gives a
// read error in any phase and restarts header collection. Configuration is
// written through the APB port at byte address 0 (magic) and 4 (version)
// and must only be changed while no frame is in progress.
`default_nettype none

module config_frame_checker_top
    import cfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    cfc_in_if.sink                     stream_in,
    cfc_out_if.source                  result_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfc_cfg_t cfg;

    cfc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Frame state
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [HDR_IDX_W-1:0] header_index_reg, header_index_next;
    logic                 magic_mismatch_reg, magic_mismatch_next;
    logic                 version_mismatch_reg, version_mismatch_next;
    logic [LEN_W-1:0]     payload_length_reg, payload_length_next;
    logic [LEN_W-1:0]     payload_count_reg, payload_count_next;
    logic [CRC_W-1:0]     expected_crc_reg, expected_crc_next;
    logic [CRC_W-1:0]     running_crc_reg, running_crc_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   payload_byte_reg, payload_byte_next;
    logic                payload_valid_reg, payload_valid_next;
    logic                status_valid_reg, status_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic              in_fire;
    logic              emit;
    logic [BYTE_W-1:0] in_byte;
    logic [CRC_W-1:0]  crc_upd;
    logic [LEN_W-1:0]  count_upd;
    logic [1:0]        byte_lane;

    assign in_byte   = stream_in.stream_byte;
    assign stream_in.ready = !out_valid_reg || result_out.ready;
    assign in_fire   = stream_in.valid && stream_in.ready;
    assign crc_upd   = crc32_byte(running_crc_reg, in_byte);
    assign count_upd = payload_count_reg + LEN_W'(1);
    assign byte_lane = header_index_reg[1:0];

    // Next frame state and result for the accepted beat
    always_comb
    begin
        phase_next            = phase_reg;
        header_index_next     = header_index_reg;
        magic_mismatch_next   = magic_mismatch_reg;
        version_mismatch_next = version_mismatch_reg;
        payload_length_next   = payload_length_reg;
        payload_count_next    = payload_count_reg;
        expected_crc_next     = expected_crc_reg;
        running_crc_next      = running_crc_reg;
        emit                  = 1'b0;
        payload_byte_next     = '0;
        payload_valid_next    = 1'b0;
        status_valid_next     = 1'b0;
        status_next           = ST_OK;

        if (in_fire)
        begin
            if (stream_in.stream_ended)
            begin
                emit              = 1'b1;
                status_valid_next = 1'b1;
                status_next       = ST_READ_ERROR;
                phase_next        = PHASE_HEADER;
            end
            else
            begin
                case (phase_reg)
                    PHASE_PAYLOAD:
                    begin
                        emit               = 1'b1;
                        payload_byte_next  = in_byte;
                        payload_valid_next = 1'b1;
                        running_crc_next   = crc_upd;
                        payload_count_next = count_upd;
                        if (count_upd == payload_length_reg)
                        begin
                            status_valid_next = 1'b1;
                            status_next = ((crc_upd ^ CRC_XOUT) == expected_crc_reg) ?
                                          ST_OK : ST_CRC_MISMATCH;
                            phase_next  = PHASE_HEADER;
                        end
                    end
                    default:
                    begin
                        // Capture header fields
                        if (header_index_reg inside {[HDR_MAGIC_FIRST:HDR_MAGIC_LAST]})
                        begin
                            if (in_byte != cfg.magic_word[{byte_lane, 3'b000} +: BYTE_W])
                                magic_mismatch_next = 1'b1;
                        end
                        else if (header_index_reg == HDR_VERSION)
                        begin
                            if (in_byte != cfg.format_version)
                                version_mismatch_next = 1'b1;
                        end
                        else if (header_index_reg == HDR_LEN_LO)
                            payload_length_next[BYTE_W-1:0] = in_byte;
                        else if (header_index_reg == HDR_LEN_HI)
                            payload_length_next[LEN_W-1:BYTE_W] = in_byte;
                        else if (header_index_reg >= HDR_CRC_FIRST)
                            expected_crc_next[{byte_lane, 3'b000} +: BYTE_W] = in_byte;

                        if (header_index_reg >= HDR_LAST)
                        begin
                            // Check the finished header
                            if (magic_mismatch_reg || version_mismatch_reg ||
                                payload_length_next == '0)
                            begin
                                emit              = 1'b1;
                                status_valid_next = 1'b1;
                                status_next = magic_mismatch_reg   ? ST_BAD_MAGIC :
                                              version_mismatch_reg ? ST_BAD_VERSION :
                                                                     ST_ZERO_LENGTH;
                                phase_next  = PHASE_HEADER;
                            end
                            else
                            begin
                                phase_next         = PHASE_PAYLOAD;
                                header_index_next  = '0;
                                payload_count_next = '0;
                                running_crc_next   = CRC_INIT;
                            end
                        end
                        else
                            header_index_next = header_index_reg + HDR_IDX_W'(1);
                    end
                endcase
            end

            // Drop back to header collection after any status
            if (status_valid_next)
            begin
                header_index_next     = '0;
                magic_mismatch_next   = 1'b0;
                version_mismatch_next = 1'b0;
                payload_length_next   = '0;
                payload_count_next    = '0;
                expected_crc_next     = '0;
                running_crc_next      = CRC_INIT;
            end
        end

        // Hold the result until taken, load a new one on emit
        if (emit)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && !result_out.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PHASE_HEADER;
            header_index_reg     <= '0;
            magic_mismatch_reg   <= 1'b0;
            version_mismatch_reg <= 1'b0;
            payload_length_reg   <= '0;
            payload_count_reg    <= '0;
            expected_crc_reg     <= '0;
            running_crc_reg      <= CRC_INIT;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            phase_reg            <= phase_next;
            header_index_reg     <= header_index_next;
            magic_mismatch_reg   <= magic_mismatch_next;
            version_mismatch_reg <= version_mismatch_next;
            payload_length_reg   <= payload_length_next;
            payload_count_reg    <= payload_count_next;
            expected_crc_reg     <= expected_crc_next;
            running_crc_reg      <= running_crc_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    // Result payload, loaded only with a new beat
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            payload_byte_reg  <= payload_byte_next;
            payload_valid_reg <= payload_valid_next;
            status_valid_reg  <= status_valid_next;
            status_reg        <= status_next;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.payload_byte  = payload_byte_reg;
    assign result_out.payload_valid = payload_valid_reg;
    assign result_out.status_valid  = status_valid_reg;
    assign result_out.status        = status_reg;

    // Every result carries a byte or a status
    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (result_out.payload_valid || result_out.status_valid))
        else $error("result beat with neither byte nor status");

    // End of stream always yields a read error next cycle
    a_end_read_error: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && stream_in.stream_ended) |=>
            (result_out.valid && result_out.status_valid &&
             result_out.status == ST_READ_ERROR))
        else $error("end of stream did not report a read error");

    // Header index stays within the header
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_index_reg <= HDR_LAST)
        else $error("header index ran past the header");

    // In payload the count trails a nonzero length
    a_count_below_length: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PHASE_PAYLOAD) |->
            (payload_length_reg != '0 && payload_count_reg < payload_length_reg))
        else $error("payload count reached or passed the frame length");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for config_frame_checker_top: byte stream in, result beats out, APB config.
// Depends on cfc_pkg and the cfc_in_if / cfc_out_if channel interfaces from the RTL.
// A behavioral frame predictor runs on every accepted byte and scores each result beat.

module tb_top
    import cfc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic                payload_valid;
        logic                status_valid;
        logic [STATUS_W-1:0] status;
    } frame_result_t;

    typedef enum int {
        FRM_GOOD,
        FRM_BAD_CRC,
        FRM_BAD_MAGIC,
        FRM_BAD_VERSION,
        FRM_ZERO_LEN,
        FRM_CUT,
        FRM_NOISE
    } frame_kind_e;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    cfc_in_if  stream_if ();
    cfc_out_if result_if ();

    config_frame_checker_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream_in  (stream_if),
        .result_out (result_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Predictor copy of the configuration and frame state
    logic [MAGIC_W-1:0]   cfg_magic;
    logic [VERSION_W-1:0] cfg_version;
    logic [PHASE_W-1:0]   fr_phase;
    logic [HDR_IDX_W-1:0] hdr_idx;
    logic                 magic_bad;
    logic                 version_bad;
    logic [LEN_W-1:0]     pay_len;
    logic [LEN_W-1:0]     pay_cnt;
    logic [CRC_W-1:0]     crc_expect;
    logic [CRC_W-1:0]     crc_run;

    frame_result_t pending_results[$];
    int            error_count;
    int            beats_sent;
    int            cycle_count;
    bit            no_idle;

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Reflected CRC-32, one data bit per step, LSB first
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] d);
        logic fb;
        for (int k = 0; k < BYTE_W; k++)
        begin
            fb = c[0] ^ d[k];
            c = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic void restart_frame();
        fr_phase    = PHASE_HEADER;
        hdr_idx     = '0;
        magic_bad   = 1'b0;
        version_bad = 1'b0;
        pay_len     = '0;
        pay_cnt     = '0;
        crc_expect  = '0;
        crc_run     = CRC_INIT;
    endfunction

    // Advance the frame predictor by one accepted byte; return 1 when a result is due
    function automatic bit frame_step(input logic [BYTE_W-1:0] b, input logic ended,
                                      output frame_result_t res);
        logic [STATUS_W-1:0] st;
        res = '0;
        if (ended)
        begin
            restart_frame();
            res.status_valid = 1'b1;
            res.status = ST_READ_ERROR;
            return 1'b1;
        end
        if (fr_phase == PHASE_PAYLOAD)
        begin
            crc_run = crc_fold(crc_run, b);
            pay_cnt = pay_cnt + 1'b1;
            res.payload_byte = b;
            res.payload_valid = 1'b1;
            if (pay_cnt == pay_len)
            begin
                res.status_valid = 1'b1;
                res.status = ((crc_run ^ CRC_XOUT) == crc_expect) ? ST_OK : ST_CRC_MISMATCH;
                restart_frame();
            end
            return 1'b1;
        end
        // Header phase; unused phase codes fall in here too
        if (hdr_idx <= HDR_MAGIC_LAST)
        begin
            if (b != cfg_magic[8*hdr_idx +: 8])
                magic_bad = 1'b1;
        end
        else if (hdr_idx == HDR_VERSION)
        begin
            if (b != cfg_version)
                version_bad = 1'b1;
        end
        else if (hdr_idx == HDR_LEN_LO)
            pay_len[7:0] = b;
        else if (hdr_idx == HDR_LEN_HI)
            pay_len[15:8] = b;
        else if (hdr_idx >= HDR_CRC_FIRST)
            crc_expect[8*(hdr_idx - HDR_CRC_FIRST) +: 8] = b;

        if (hdr_idx == HDR_LAST)
        begin
            if (magic_bad)
                st = ST_BAD_MAGIC;
            else if (version_bad)
                st = ST_BAD_VERSION;
            else if (pay_len == '0)
                st = ST_ZERO_LENGTH;
            else
            begin
                fr_phase = PHASE_PAYLOAD;
                hdr_idx  = '0;
                pay_cnt  = '0;
                crc_run  = CRC_INIT;
                return 1'b0;
            end
            restart_frame();
            res.status_valid = 1'b1;
            res.status = st;
            return 1'b1;
        end
        hdr_idx = hdr_idx + 1'b1;
        return 1'b0;
    endfunction

    function automatic int draw_wait();
        if (no_idle)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // Score every result beat against the oldest prediction
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: payload_byte %02h status_valid %0b status %0d",
                       result_if.payload_byte, result_if.status_valid, result_if.status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_if.payload_byte !== want.payload_byte)
                begin
                    $error("payload_byte expected %02h actual %02h",
                           want.payload_byte, result_if.payload_byte);
                    error_count++;
                end
                if (result_if.payload_valid !== want.payload_valid)
                begin
                    $error("payload_valid expected %0b actual %0b",
                           want.payload_valid, result_if.payload_valid);
                    error_count++;
                end
                if (result_if.status_valid !== want.status_valid)
                begin
                    $error("status_valid expected %0b actual %0b",
                           want.status_valid, result_if.status_valid);
                    error_count++;
                end
                if (result_if.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, result_if.status);
                    error_count++;
                end
            end
        end
    end

    // Result side: stall a random number of cycles before each beat
    initial
    begin
        int stall;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait();
            @(negedge clk);
            if (stall > 0)
            begin
                result_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_if.ready = 1'b1;
            do @(posedge clk); while (!(result_if.valid && result_if.ready));
        end
    end

    // Send one stream beat after a random gap; predict its result on acceptance
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic ended);
        int gap;
        frame_result_t res;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            stream_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        stream_if.stream_byte  = b;
        stream_if.stream_ended = ended;
        stream_if.valid        = 1'b1;
        do @(posedge clk); while (!stream_if.ready);
        if (frame_step(b, ended, res))
            pending_results.insert(pending_results.size(), res);
        beats_sent++;
    endtask

    // Drop valid and hold until every predicted beat has come back
    task automatic drain_results();
        @(negedge clk);
        stream_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Send the twelve header bytes; an end marker replaces byte number cut
    task automatic push_header(input logic [MAGIC_W-1:0] magic,
                               input logic [VERSION_W-1:0] ver,
                               input logic [BYTE_W-1:0] flags,
                               input logic [LEN_W-1:0] len,
                               input logic [CRC_W-1:0] crc,
                               input int cut);
        logic [8*HEADER_BYTES-1:0] hdr;
        hdr = {crc, len, flags, ver, magic};
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            if (i == cut)
            begin
                push_byte(8'($urandom), 1'b1);
                return;
            end
            push_byte(hdr[8*i +: 8], 1'b0);
        end
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return LEN_W'($urandom_range(1, 8));
        else if (r < 95)
            return LEN_W'($urandom_range(9, 64));
        return LEN_W'($urandom_range(65, 300));
    endfunction

    // Build and send one frame of the given kind; len_req of zero picks a length
    task automatic send_frame(input frame_kind_e kind, input int len_req, input bit hold_mid);
        logic [BYTE_W-1:0]    body[$];
        logic [BYTE_W-1:0]    pb;
        logic [LEN_W-1:0]     len;
        logic [CRC_W-1:0]     crc;
        logic [MAGIC_W-1:0]   magic;
        logic [VERSION_W-1:0] ver;
        int                   cut;
        int                   n;

        // Noise: random bytes with stray end markers, closed by an end marker
        if (kind == FRM_NOISE)
        begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom), $urandom_range(0, 15) == 0);
            push_byte(8'($urandom), 1'b1);
            return;
        end

        len = (len_req != 0) ? LEN_W'(len_req) : pick_length();
        if (kind == FRM_ZERO_LEN)
            len = '0;
        else if (kind == FRM_BAD_MAGIC || kind == FRM_BAD_VERSION)
            len = LEN_W'($urandom_range(0, 16'hFFFF));
        else if (kind == FRM_CUT && $urandom_range(0, 1) == 1)
            len = LEN_W'($urandom_range(1, 16'hFFFF));

        // Payload and its CRC
        crc = CRC_INIT;
        if (kind == FRM_GOOD || kind == FRM_BAD_CRC)
        begin
            for (int i = 0; i < len; i++)
            begin
                pb = 8'($urandom);
                body.insert(body.size(), pb);
                crc = crc_fold(crc, pb);
            end
            crc = crc ^ CRC_XOUT;
            if (kind == FRM_BAD_CRC)
                crc = crc ^ (32'h1 << $urandom_range(0, 31));
        end
        else
            crc = $urandom;

        magic = cfg_magic;
        ver   = cfg_version;
        if (kind == FRM_BAD_MAGIC)
        begin
            magic = magic ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
            if ($urandom_range(0, 1) == 1)
                ver = ver ^ 8'($urandom_range(1, 255));
        end
        else if (kind == FRM_BAD_VERSION)
            ver = ver ^ 8'($urandom_range(1, 255));

        cut = -1;
        if (kind == FRM_CUT)
            cut = $urandom_range(0, HEADER_BYTES - 1 + ((len < 24) ? int'(len) : 24));

        push_header(magic, ver, 8'($urandom), len, crc, cut);
        if (cut >= 0 && cut < HEADER_BYTES)
            return;
        if (kind == FRM_BAD_MAGIC || kind == FRM_BAD_VERSION || kind == FRM_ZERO_LEN)
            return;

        for (int i = 0; i < len; i++)
        begin
            if (hold_mid && i == len / 2)
                drain_results();
            if (HEADER_BYTES + i == cut)
            begin
                push_byte(8'($urandom), 1'b1);
                return;
            end
            push_byte((kind == FRM_CUT) ? 8'($urandom) : body[i], 1'b0);
        end
    endtask

    // One APB transfer: setup cycle, access cycle, done when pready is seen
    task automatic apb_access(input logic [CFG_IDX_W-1:0] idx, input logic wr,
                              input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = CFG_ADDR_W'(idx) << 2;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_reg(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] got;
        logic [CFG_DATA_W-1:0] want;
        apb_access(idx, 1'b0, '0, got);
        want = (idx == REG_MAGIC_WORD) ? CFG_DATA_W'(cfg_magic) : CFG_DATA_W'(cfg_version);
        if (got !== want)
        begin
            $error("%s expected %08h actual %08h",
                   (idx == REG_MAGIC_WORD) ? "magic_word" : "format_version", want, got);
            error_count++;
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        logic [CFG_DATA_W-1:0] unused;
        apb_access(idx, 1'b1, v, unused);
        if (idx == REG_MAGIC_WORD)
            cfg_magic = v[MAGIC_W-1:0];
        else
            cfg_version = v[VERSION_W-1:0];
        check_reg(idx);
    endtask

    // Close any open frame, let the block go quiet, then load a new setting
    task automatic apply_config(input logic [MAGIC_W-1:0] magic,
                                input logic [VERSION_W-1:0] ver);
        if (fr_phase == PHASE_PAYLOAD || hdr_idx != '0)
            push_byte(8'($urandom), 1'b1);
        drain_results();
        cfg_write(REG_MAGIC_WORD, CFG_DATA_W'(magic));
        cfg_write(REG_FORMAT_VERSION, CFG_DATA_W'(ver));
    endtask

    task automatic test_register_defaults();
        check_reg(REG_MAGIC_WORD);
        check_reg(REG_FORMAT_VERSION);
    endtask

    // End marker before any header, a clean one-byte frame, and a header that is
    // wrong in every field so bad magic must win
    task automatic test_directed_frames();
        logic [CRC_W-1:0] crc;
        push_byte(8'hFF, 1'b1);
        crc = crc_fold(CRC_INIT, 8'hFF) ^ CRC_XOUT;
        push_header(cfg_magic, cfg_version, 8'hFF, 16'd1, crc, -1);
        push_byte(8'hFF, 1'b0);
        push_header('0, '0, '0, '0, '0, -1);
        drain_results();
    endtask

    // Well-formed frames with random content, mixed with broken frames and noise
    task automatic test_random_frames(input int target);
        int start;
        int r;
        frame_kind_e kind;
        start = beats_sent;
        while (beats_sent - start < target)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 40)
                kind = FRM_GOOD;
            else if (r < 55)
                kind = FRM_BAD_CRC;
            else if (r < 63)
                kind = FRM_BAD_MAGIC;
            else if (r < 71)
                kind = FRM_BAD_VERSION;
            else if (r < 78)
                kind = FRM_ZERO_LEN;
            else if (r < 90)
                kind = FRM_CUT;
            else
                kind = FRM_NOISE;
            send_frame(kind, 0, $urandom_range(0, 19) == 0);
        end
        no_idle = 1'b0;
    endtask

    // Long payload at full rate, with the sender holding off halfway
    task automatic test_long_payload();
        no_idle = 1'b1;
        send_frame(FRM_GOOD, 512, 1'b1);
        no_idle = 1'b0;
        drain_results();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stream_if.valid = 1'b0;
        stream_if.stream_byte = '0;
        stream_if.stream_ended = 1'b0;
        error_count = 0;
        beats_sent = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        cfg_magic = MAGIC_RESET;
        cfg_version = VERSION_RESET;
        restart_frame();

        // Hold reset, then release it at a falling clock edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_defaults();
        test_directed_frames();
        test_random_frames(140);
        test_long_payload();
        apply_config(32'h0000_0000, 8'h00);
        test_random_frames(140);
        apply_config(32'hFFFF_FFFF, 8'hFF);
        test_random_frames(140);
        apply_config(32'($urandom), 8'($urandom));
        test_random_frames(140);
        apply_config(32'($urandom), 8'($urandom));
        test_random_frames(140);
        apply_config(MAGIC_RESET, VERSION_RESET);
        test_random_frames(140);

        drain_results();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
